@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the converter
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

@@ sv/rhc_pkg.sv @@
// ----------------------------------------------------------------------------
// rhc_pkg
// shared types and constants of the colour converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rhc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // conversion selector codes: source*3 + target
  localparam logic [3:0] FN_RGB_RGB = 4'd0;
  localparam logic [3:0] FN_RGB_HSV = 4'd1;
  localparam logic [3:0] FN_RGB_CMY = 4'd2;
  localparam logic [3:0] FN_HSV_RGB = 4'd3;
  localparam logic [3:0] FN_HSV_HSV = 4'd4;
  localparam logic [3:0] FN_HSV_CMY = 4'd5;
  localparam logic [3:0] FN_CMY_RGB = 4'd6;
  localparam logic [3:0] FN_CMY_HSV = 4'd7;
  localparam logic [3:0] FN_CMY_CMY = 4'd8;

  typedef enum logic [1:0] {
    OP_COPY,
    OP_TO_HSV,
    OP_FROM_HSV
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] base;    // hue base in thirds of a turn (0, 2/6, 4/6)
    logic       neg;     // hue offset is negative
    logic       inv;     // complement results (cmy target)
    logic [2:0] sector;
    logic       zero;    // zero chroma or zero saturation
  } ctrl_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [FIFO_CW-1:0] count;
  } fifo_stat_t;

endpackage

@@ sv/rhc_if.sv @@
// ----------------------------------------------------------------------------
// rhc_if
// valid/ready stream interfaces for pixel words in and out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rhc_in_if import rhc_pkg::*; #(parameter int W = FRAC_BITS_DEF + 1);
  logic         valid;
  logic         ready;
  logic [3:0]   func;
  logic [W-1:0] comp_a;
  logic [W-1:0] comp_b;
  logic [W-1:0] comp_c;

  modport source (output valid, func, comp_a, comp_b, comp_c, input ready);
  modport sink (input valid, func, comp_a, comp_b, comp_c, output ready);
endinterface

interface rhc_out_if import rhc_pkg::*; #(parameter int W = FRAC_BITS_DEF + 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] out_a;
  logic [W-1:0] out_b;
  logic [W-1:0] out_c;

  modport source (output valid, out_a, out_b, out_c, input ready);
  modport sink (input valid, out_a, out_b, out_c, output ready);
endinterface

@@ sv/rhc_front.sv @@
// ----------------------------------------------------------------------------
// rhc_front
// accepts pixel words, saturates and classifies them for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhc_front import rhc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  rhc_in_if.sink                pix_in,
  input  logic                  full,
  output logic                  push,
  output ctrl_t                 ctrl,
  output logic [FRAC_BITS:0]    d0,
  output logic [FRAC_BITS:0]    d1,
  output logic [FRAC_BITS:0]    d2
);

  localparam int W  = FRAC_BITS + 1;
  localparam int HW = FRAC_BITS + 3;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [W-1:0]  a, b, c;
  logic          cmy_src;
  logic [W-1:0]  r, g, bl;
  logic [W-1:0]  mx, mn, delta;
  logic [1:0]    sel;
  logic [W-1:0]  x1, x2;
  logic          neg;
  logic [W-1:0]  mag;
  logic [W-1:0]  h;
  logic [HW-1:0] h6;

  assign pix_in.ready = !full;
  assign push         = pix_in.valid && !full;

  assign a = (pix_in.comp_a > ONE) ? ONE : pix_in.comp_a;
  assign b = (pix_in.comp_b > ONE) ? ONE : pix_in.comp_b;
  assign c = (pix_in.comp_c > ONE) ? ONE : pix_in.comp_c;

  // rgb view for the to-hsv path
  assign cmy_src = (pix_in.func == FN_CMY_HSV);
  assign r  = cmy_src ? ONE - a : a;
  assign g  = cmy_src ? ONE - b : b;
  assign bl = cmy_src ? ONE - c : c;

  always_comb begin
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (bl > mx) mx = bl;
    if (g < mn) mn = g;
    if (bl < mn) mn = bl;
    // red wins ties, then green
    if (r == mx) begin
      sel = 2'd0;
      x1  = g;
      x2  = bl;
    end else if (g == mx) begin
      sel = 2'd1;
      x1  = bl;
      x2  = r;
    end else begin
      sel = 2'd2;
      x1  = r;
      x2  = g;
    end
  end

  assign delta = mx - mn;
  assign neg   = x1 < x2;
  assign mag   = neg ? x2 - x1 : x1 - x2;

  // hue of one wraps to zero, then scale by six
  assign h  = (a == ONE) ? '0 : a;
  assign h6 = (HW'(h) << 2) + (HW'(h) << 1);

  always_comb begin
    ctrl = '{op: OP_COPY, base: 2'd0, neg: 1'b0, inv: 1'b0, sector: 3'd0, zero: 1'b0};
    d0   = '0;
    d1   = '0;
    d2   = '0;
    case (pix_in.func)
      FN_RGB_RGB, FN_HSV_HSV, FN_CMY_CMY: begin
        d0 = a;
        d1 = b;
        d2 = c;
      end
      FN_RGB_CMY, FN_CMY_RGB: begin
        d0 = ONE - a;
        d1 = ONE - b;
        d2 = ONE - c;
      end
      FN_RGB_HSV, FN_CMY_HSV: begin
        ctrl.op   = OP_TO_HSV;
        ctrl.base = sel;
        ctrl.neg  = neg;
        ctrl.zero = (delta == '0);
        d0 = delta;
        d1 = mx;
        d2 = mag;
      end
      FN_HSV_RGB, FN_HSV_CMY: begin
        ctrl.op     = OP_FROM_HSV;
        ctrl.inv    = (pix_in.func == FN_HSV_CMY);
        ctrl.sector = h6[FRAC_BITS+2:FRAC_BITS];
        ctrl.zero   = (b == '0);
        d0 = c;
        d1 = b;
        d2 = W'(h6[FRAC_BITS-1:0]);
      end
      default: begin
        d0 = '0;
      end
    endcase
  end

endmodule

@@ sv/rhc_fifo.sv @@
// ----------------------------------------------------------------------------
// rhc_fifo
// short queue that decouples the front from the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhc_fifo import rhc_pkg::*; #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] din,
  input  logic          pop,
  output logic [DW-1:0] dout,
  output fifo_stat_t    stat
);

  logic [DW-1:0]      mem [0:FIFO_DEPTH-1];
  logic [FIFO_AW-1:0] wptr, rptr;
  logic [FIFO_CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

  assign dout       = mem[rptr];
  assign stat.count = count;
  assign stat.empty = (count == '0);
  assign stat.full  = (count == FIFO_CW'(FIFO_DEPTH));

endmodule

@@ sv/rhc_back.sv @@
// ----------------------------------------------------------------------------
// rhc_back
// divider pipeline, product stages and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhc_back import rhc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               avail,
  output logic               pop,
  input  ctrl_t              ctrl_i,
  input  logic [FRAC_BITS:0] d0_i,
  input  logic [FRAC_BITS:0] d1_i,
  input  logic [FRAC_BITS:0] d2_i,
  rhc_out_if.source          pix_out,
  output logic               busy
);

  localparam int W   = FRAC_BITS + 1;
  localparam int NS  = FRAC_BITS + 1;
  localparam int RW  = W + 1;
  localparam int HW  = FRAC_BITS + 3;
  localparam int KSH = FRAC_BITS + 5;
  localparam longint unsigned RECIP_L = ((64'd1 << KSH) + 64'd5) / 64'd6;
  localparam logic [HW-1:0] RECIP = HW'(RECIP_L);
  localparam logic [W-1:0]  ONE   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [HW-1:0] SIX   = HW'(6) << FRAC_BITS;

  logic adv;

  // divider stages
  logic [NS:0]   vld;
  ctrl_t         dctrl [0:NS];
  logic [W-1:0]  dd0   [0:NS];
  logic [W-1:0]  dd1   [0:NS];
  logic [W-1:0]  dd2   [0:NS];
  logic [RW-1:0] rs    [0:NS];
  logic [RW-1:0] rh    [0:NS];
  logic [W-1:0]  qs    [0:NS];
  logic [W-1:0]  qh    [0:NS];

  assign adv = !pix_out.valid || pix_out.ready;
  assign pop = adv && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-1:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dctrl[0] <= ctrl_i;
      dd0[0]   <= d0_i;
      dd1[0]   <= d1_i;
      dd2[0]   <= d2_i;
      rs[0]    <= {1'b0, d0_i};
      rh[0]    <= {1'b0, d2_i};
      qs[0]    <= '0;
      qh[0]    <= '0;
    end
  end

  // one quotient bit per stage for saturation and hue offset
  for (genvar i = 0; i < NS; i++) begin : g_div
    logic          bs, bh;
    logic [RW-1:0] ss, sh;

    assign bs = rs[i] >= {1'b0, dd1[i]};
    assign bh = rh[i] >= {1'b0, dd0[i]};
    assign ss = bs ? rs[i] - {1'b0, dd1[i]} : rs[i];
    assign sh = bh ? rh[i] - {1'b0, dd0[i]} : rh[i];

    always_ff @(posedge clk) begin
      if (adv) begin
        dctrl[i+1] <= dctrl[i];
        dd0[i+1]   <= dd0[i];
        dd1[i+1]   <= dd1[i];
        dd2[i+1]   <= dd2[i];
        rs[i+1]    <= ss << 1;
        rh[i+1]    <= sh << 1;
        qs[i+1]    <= {qs[i][W-2:0], bs};
        qh[i+1]    <= {qh[i][W-2:0], bh};
      end
    end
  end

  // stage a: hue in sixths, first products
  logic [HW-1:0]  pos, qe, h6;
  logic [2*W-1:0] pm0, pm1, pm2;
  logic           a_vld;
  ctrl_t          a_ctrl;
  logic [W-1:0]   a_d0, a_d1, a_d2, a_s, a_p, a_sf, a_sf2;
  logic [HW-1:0]  a_h6;

  assign pos = HW'({dctrl[NS].base, 1'b0}) << FRAC_BITS;
  assign qe  = HW'(qh[NS]);
  always_comb begin
    if (!dctrl[NS].neg) h6 = pos + qe;
    else if (pos >= qe) h6 = pos - qe;
    else h6 = pos + SIX - qe;
  end

  assign pm0 = (2*W)'(dd0[NS]) * (2*W)'(ONE - dd1[NS]);
  assign pm1 = (2*W)'(dd1[NS]) * (2*W)'(dd2[NS]);
  assign pm2 = (2*W)'(dd1[NS]) * (2*W)'(ONE - dd2[NS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ctrl <= dctrl[NS];
      a_d0   <= dd0[NS];
      a_d1   <= dd1[NS];
      a_d2   <= dd2[NS];
      a_s    <= qs[NS];
      a_h6   <= h6;
      a_p    <= W'(pm0 >> FRAC_BITS);
      a_sf   <= W'(pm1 >> FRAC_BITS);
      a_sf2  <= W'(pm2 >> FRAC_BITS);
    end
  end

  // stage b: divide by six via reciprocal, second products
  logic [2*HW-1:0] ph;
  logic [2*W-1:0]  pq, pt;
  logic            b_vld;
  ctrl_t           b_ctrl;
  logic [W-1:0]    b_d0, b_d1, b_d2, b_s, b_p, b_h, b_q, b_t;

  assign ph = (2*HW)'(a_h6) * (2*HW)'(RECIP);
  assign pq = (2*W)'(a_d0) * (2*W)'(ONE - a_sf);
  assign pt = (2*W)'(a_d0) * (2*W)'(ONE - a_sf2);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_ctrl <= a_ctrl;
      b_d0   <= a_d0;
      b_d1   <= a_d1;
      b_d2   <= a_d2;
      b_s    <= a_s;
      b_p    <= a_p;
      b_h    <= W'(ph >> KSH);
      b_q    <= W'(pq >> FRAC_BITS);
      b_t    <= W'(pt >> FRAC_BITS);
    end
  end

  // output select and register
  logic [W-1:0] ra, rb, rc, sa, sb, sc;
  logic         ovalid;
  logic [W-1:0] oa, ob, oc;

  always_comb begin
    case (b_ctrl.sector)
      3'd0:    begin sa = b_d0; sb = b_t;  sc = b_p;  end
      3'd1:    begin sa = b_q;  sb = b_d0; sc = b_p;  end
      3'd2:    begin sa = b_p;  sb = b_d0; sc = b_t;  end
      3'd3:    begin sa = b_p;  sb = b_q;  sc = b_d0; end
      3'd4:    begin sa = b_t;  sb = b_p;  sc = b_d0; end
      default: begin sa = b_d0; sb = b_p;  sc = b_q;  end
    endcase
    if (b_ctrl.zero) begin
      sa = b_d0;
      sb = b_d0;
      sc = b_d0;
    end
    case (b_ctrl.op)
      OP_TO_HSV: begin
        ra = b_ctrl.zero ? '0 : b_h;
        rb = b_ctrl.zero ? '0 : b_s;
        rc = b_d1;
      end
      OP_FROM_HSV: begin
        ra = b_ctrl.inv ? ONE - sa : sa;
        rb = b_ctrl.inv ? ONE - sb : sb;
        rc = b_ctrl.inv ? ONE - sc : sc;
      end
      default: begin
        ra = b_d0;
        rb = b_d1;
        rc = b_d2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (adv) begin
      ovalid <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oa <= ra;
      ob <= rb;
      oc <= rc;
    end
  end

  assign pix_out.valid = ovalid;
  assign pix_out.out_a = oa;
  assign pix_out.out_b = ob;
  assign pix_out.out_c = oc;

  assign busy = (|vld) || a_vld || b_vld;

endmodule

@@ sv/rgb_hsv_cmy_colour_converter.sv @@
// ----------------------------------------------------------------------------
// rgb_hsv_cmy_colour_converter
// pixel colour conversion among rgb, hsv and cmy; without output stalls, one word per cycle
// ----------------------------------------------------------------------------
// usage:
//   pix_in carries a selector (source*3 + target) and three Q1.16 components;
//   pix_out returns the three converted components, one result word per input
//   word, in order. both channels use valid/ready; a word moves when both high
// throughput: one word per cycle sustained while pix_out takes every word, set by the fully
//   pipelined back end (one quotient bit per divider stage, two product stages)
// path: an accepted word passes the front queue, the divider input register, the
//   divider stages, stage a, stage b and the output register
// reset: synchronous rst empties the front queue and clears all stage valids;
//   no word is in flight afterwards
// stall: when pix_out is held, the whole back end freezes with its output
//   register; the front keeps taking words until the four-entry queue fills,
//   then pix_in.ready drops
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgb_hsv_cmy_colour_converter import rhc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  rhc_in_if.sink    pix_in,
  rhc_out_if.source pix_out
);

  localparam int W  = FRAC_BITS + 1;
  localparam int DW = $bits(ctrl_t) + 3 * W;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // front side: classify into queue entries
  logic         push;
  ctrl_t        f_ctrl;
  logic [W-1:0] f_d0, f_d1, f_d2;

  // queue
  logic [DW-1:0] q_din, q_dout;
  fifo_stat_t    fstat;

  // back side
  logic         pop;
  ctrl_t        b_ctrl;
  logic [W-1:0] b_d0, b_d1, b_d2;
  logic         busy;

  rhc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .pix_in (pix_in),
    .full   (fstat.full),
    .push   (push),
    .ctrl   (f_ctrl),
    .d0     (f_d0),
    .d1     (f_d1),
    .d2     (f_d2)
  );

  assign q_din = {f_ctrl, f_d0, f_d1, f_d2};

  rhc_fifo #(.DW(DW)) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (q_din),
    .pop  (pop),
    .dout (q_dout),
    .stat (fstat)
  );

  assign {b_ctrl, b_d0, b_d1, b_d2} = q_dout;

  rhc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .avail   (!fstat.empty),
    .pop     (pop),
    .ctrl_i  (b_ctrl),
    .d0_i    (b_d0),
    .d1_i    (b_d1),
    .d2_i    (b_d2),
    .pix_out (pix_out),
    .busy    (busy)
  );

  // queue occupancy follows push and pop exactly
  `ASSERT_PROP(a_fifo_count, clk, rst, !rst |=> (fstat.count == $past(fstat.count) + FIFO_CW'($past(push)) - FIFO_CW'($past(pop))))
  // back end never draws from an empty queue
  `ASSERT_NEVER(a_pop_empty, clk, rst, pop && fstat.empty)
  // every converted component stays within one
  `ASSERT_PROP(a_out_range, clk, rst, pix_out.valid |-> (pix_out.out_a <= ONE && pix_out.out_b <= ONE && pix_out.out_c <= ONE))
  // an idle block does not invent a word
  `ASSERT_PROP(a_no_phantom, clk, rst, (!pix_out.valid && !busy && fstat.empty) |=> !pix_out.valid)

endmodule

@@ tb/tb_rgb_hsv_cmy_colour_converter.sv @@
// ----------------------------------------------------------------------------
// tb_rgb_hsv_cmy_colour_converter
// streams pixel words through the converter under several idle patterns and
// checks every result word against a behavioral fixed point predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rgb_hsv_cmy_colour_converter;
  import rhc_pkg::*;

  localparam int FB  = FRAC_BITS_DEF;
  localparam int W   = FB + 1;
  localparam longint unsigned ONE = 64'd1 << FB;
  localparam int LAT = FB + 5;
  localparam int LIMIT = 2000000;

  typedef struct {
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] c;
  } pixel_t;

  // hue offset in sixths, magnitude truncated then signed
  function automatic longint hue_offset(longint unsigned x, longint unsigned y,
                                        longint unsigned d);
    if (x >= y) return longint'(((x - y) << FB) / d);
    return -longint'(((y - x) << FB) / d);
  endfunction

  function automatic pixel_t to_hsv(longint unsigned r, longint unsigned g,
                                    longint unsigned b);
    longint unsigned mx, mn, s, h, d;
    longint h6;
    pixel_t p;
    mx = r; mn = r; s = 0; h = 0;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    if (mx != 0) s = ((mx - mn) << FB) / mx;
    if (s != 0) begin
      d = mx - mn;
      if (r == mx) h6 = hue_offset(g, b, d);
      else if (g == mx) h6 = 2 * longint'(ONE) + hue_offset(b, r, d);
      else h6 = 4 * longint'(ONE) + hue_offset(r, g, d);
      if (h6 < 0) h6 += 6 * longint'(ONE);
      h = longint'(h6) / 6;
    end
    p.a = h[W-1:0]; p.b = s[W-1:0]; p.c = mx[W-1:0];
    return p;
  endfunction

  function automatic pixel_t from_hsv(longint unsigned h, longint unsigned s,
                                      longint unsigned v);
    longint unsigned h6, f, lo, fall, rise;
    pixel_t p;
    if (s == 0) begin
      p.a = v[W-1:0]; p.b = v[W-1:0]; p.c = v[W-1:0];
      return p;
    end
    if (h >= ONE) h = 0;
    h6 = h * 6;
    f = h6 & (ONE - 1);
    lo = (v * (ONE - s)) >> FB;
    fall = (v * (ONE - ((s * f) >> FB))) >> FB;
    rise = (v * (ONE - ((s * (ONE - f)) >> FB))) >> FB;
    case (h6 >> FB)
      0: begin p.a = v[W-1:0]; p.b = rise[W-1:0]; p.c = lo[W-1:0]; end
      1: begin p.a = fall[W-1:0]; p.b = v[W-1:0]; p.c = lo[W-1:0]; end
      2: begin p.a = lo[W-1:0]; p.b = v[W-1:0]; p.c = rise[W-1:0]; end
      3: begin p.a = lo[W-1:0]; p.b = fall[W-1:0]; p.c = v[W-1:0]; end
      4: begin p.a = rise[W-1:0]; p.b = lo[W-1:0]; p.c = v[W-1:0]; end
      default: begin p.a = v[W-1:0]; p.b = lo[W-1:0]; p.c = fall[W-1:0]; end
    endcase
    return p;
  endfunction

  function automatic pixel_t convert_pixel(logic [3:0] fn, logic [W-1:0] ia,
                                           logic [W-1:0] ib, logic [W-1:0] ic);
    longint unsigned a, b, c;
    pixel_t p;
    // components above one saturate first
    a = (64'(ia) > ONE) ? ONE : 64'(ia);
    b = (64'(ib) > ONE) ? ONE : 64'(ib);
    c = (64'(ic) > ONE) ? ONE : 64'(ic);
    p.a = '0; p.b = '0; p.c = '0;
    case (fn)
      FN_RGB_RGB, FN_HSV_HSV, FN_CMY_CMY: begin
        p.a = a[W-1:0]; p.b = b[W-1:0]; p.c = c[W-1:0];
      end
      FN_RGB_HSV: p = to_hsv(a, b, c);
      FN_RGB_CMY, FN_CMY_RGB: begin
        p.a = W'(ONE - a); p.b = W'(ONE - b); p.c = W'(ONE - c);
      end
      FN_HSV_RGB: p = from_hsv(a, b, c);
      FN_HSV_CMY: begin
        p = from_hsv(a, b, c);
        p.a = ONE[W-1:0] - p.a; p.b = ONE[W-1:0] - p.b; p.c = ONE[W-1:0] - p.c;
      end
      FN_CMY_HSV: p = to_hsv(ONE - a, ONE - b, ONE - c);
      default: ;  // selector without meaning gives zeros
    endcase
    return p;
  endfunction

  class pixel_scoreboard;
    pixel_t pending[$];
    int errors = 0;

    function void note_input(logic [3:0] fn, logic [W-1:0] a, logic [W-1:0] b,
                             logic [W-1:0] c);
      pending.push_back(convert_pixel(fn, a, b, c));
    endfunction

    function void check_result(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] c);
      pixel_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h %h %h", a, b, c);
        return;
      end
      e = pending.pop_front();
      if (e.a !== a || e.b !== b || e.c !== c) begin
        errors++;
        if (errors <= 10)
          $display("result word: expected %h %h %h got %h %h %h",
                   e.a, e.b, e.c, a, b, c);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  rhc_in_if  #(.W(W)) pix_in ();
  rhc_out_if #(.W(W)) pix_out ();

  rgb_hsv_cmy_colour_converter dut (
    .clk(clk), .rst(rst), .pix_in(pix_in.sink), .pix_out(pix_out.source)
  );

  pixel_scoreboard sb = new();
  int send_idle = 0;    // percent of cycles the sender idles
  int recv_stall = 0;   // percent of cycles the receiver stalls
  int hold_cycles = 0;  // long receiver hold-off request
  longint cycles = 0;

  initial begin
    pix_in.valid = 1'b0;
    pix_in.func = '0;
    pix_in.comp_a = '0;
    pix_in.comp_b = '0;
    pix_in.comp_c = '0;
    pix_out.ready = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      pix_out.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      pix_out.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      pix_out.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // monitor both channels at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (pix_in.valid && pix_in.ready)
        sb.note_input(pix_in.func, pix_in.comp_a, pix_in.comp_b, pix_in.comp_c);
      if (pix_out.valid && pix_out.ready)
        sb.check_result(pix_out.out_a, pix_out.out_b, pix_out.out_c);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("rgb_hsv_cmy_colour_converter: mismatch");
      $finish;
    end
  end

  function automatic logic [W-1:0] rand_comp();
    case ($urandom_range(9))
      0: return '0;
      1: return ONE[W-1:0];
      2: return W'($urandom);             // may exceed one
      3: return ONE[W-1:0] - W'($urandom_range(3));
      default: return W'($urandom_range(ONE));
    endcase
  endfunction

  // one word: optional idle cycles, then hold valid until accepted
  task automatic send_word(logic [3:0] fn, logic [W-1:0] a, logic [W-1:0] b,
                           logic [W-1:0] c);
    while ($urandom_range(99) < send_idle) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.func <= fn;
    pix_in.comp_a <= a;
    pix_in.comp_b <= b;
    pix_in.comp_c <= c;
    do @(posedge clk); while (!pix_in.ready);
  endtask

  task automatic send_random(int n);
    logic [3:0] fn;
    repeat (n) begin
      fn = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9))
                                     : 4'($urandom_range(8));
      send_word(fn, rand_comp(), rand_comp(), rand_comp());
    end
  endtask

  task automatic drain();
    pix_in.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every selector, zero value and zero saturation,
    // hue of one, max ties, bad selectors, all bits of each field
    for (int f = 0; f < 9; f++) send_word(4'(f), ONE[W-1:0], 17'h1ffff, 17'h0);
    send_word(FN_RGB_HSV, '0, '0, '0);
    send_word(FN_RGB_HSV, 17'h8000, 17'h8000, 17'h8000);
    send_word(FN_RGB_HSV, 17'h9000, 17'h9000, 17'h1000);
    send_word(FN_RGB_HSV, 17'h1000, 17'h9000, 17'h9000);
    send_word(FN_RGB_HSV, 17'h9000, 17'h1000, 17'h5000);
    send_word(FN_CMY_HSV, ONE[W-1:0], ONE[W-1:0], ONE[W-1:0]);
    send_word(FN_HSV_RGB, ONE[W-1:0], 17'h8000, 17'hc000);
    send_word(FN_HSV_RGB, 17'h4000, '0, 17'h7000);
    send_word(FN_HSV_CMY, 17'h4000, '0, 17'h7000);
    send_word(FN_HSV_CMY, 17'hffff, ONE[W-1:0], ONE[W-1:0]);
    send_word(4'd9, 17'h1234, 17'h1234, 17'h1234);
    send_word(4'd15, 17'h1ffff, 17'h1ffff, 17'h1ffff);
    drain();

    // random phases with different idle patterns
    send_random(400);
    send_idle = 81;
    send_random(300);
    drain();
    send_idle = 0; recv_stall = 81;
    send_random(300);
    send_idle = 18; recv_stall = 18;
    send_random(300);
    // long receiver hold-off while the sender keeps offering words
    send_idle = 0; recv_stall = 0;
    hold_cycles <= 200;
    send_random(200);
    drain();
    send_random(200);
    drain();

    repeat (LAT + 5) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("rgb_hsv_cmy_colour_converter: match");
    end else begin
      $display("rgb_hsv_cmy_colour_converter: mismatch");
    end
    $finish;
  end
endmodule

@@ rgb_hsv_cmy_colour_converter.f @@
+incdir+sv
sv/rhc_pkg.sv
sv/rhc_if.sv
sv/rhc_front.sv
sv/rhc_fifo.sv
sv/rhc_back.sv
sv/rgb_hsv_cmy_colour_converter.sv
tb/tb_rgb_hsv_cmy_colour_converter.sv
